// File: rtl/core/bbe_pkg.sv
package bbe_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_RADIUS  = 7;
    localparam int STORE_DEPTH = MAX_WIDTH * (2 * MAX_RADIUS + 1);

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WCFG_W  = COL_W + 1;
    localparam int HCFG_W  = ROW_W + 1;
    localparam int LIN_W   = COL_W + ROW_W + 1;
    localparam int SUM_W   = 16;
    localparam int CNT_W   = 8;
    localparam int PIX_W   = 24;

    // register indexes
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // input item kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sums_t;

endpackage

// File: rtl/core/bbe_div.sv
module bbe_div
    import bbe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sums_t            sums,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [7:0]       q_red,
    output logic [7:0]       q_green,
    output logic [7:0]       q_blue
);

    logic             busy_reg, busy_next;
    logic [4:0]       step_reg, step_next;
    logic [SUM_W:0]   rem_reg [3], rem_next [3];
    logic [SUM_W-1:0] quo_reg [3], quo_next [3];
    logic [CNT_W-1:0] dvs_reg;
    logic [SUM_W:0]   trial [3];

    // one restoring step on all three channels
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        for (int i = 0; i < 3; i++)
        begin
            rem_next[i] = rem_reg[i];
            quo_next[i] = quo_reg[i];
            trial[i]    = {rem_reg[i][SUM_W-1:0], quo_reg[i][SUM_W-1]};
        end
        if (start)
        begin
            busy_next   = 1'b1;
            step_next   = 5'd0;
            rem_next[0] = '0;
            rem_next[1] = '0;
            rem_next[2] = '0;
            quo_next[0] = sums.red;
            quo_next[1] = sums.green;
            quo_next[2] = sums.blue;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (trial[i] >= {{(SUM_W+1-CNT_W){1'b0}}, dvs_reg})
                begin
                    rem_next[i] = trial[i] - {{(SUM_W+1-CNT_W){1'b0}}, dvs_reg};
                    quo_next[i] = {quo_reg[i][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = trial[i];
                    quo_next[i] = {quo_reg[i][SUM_W-2:0], 1'b0};
                end
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(SUM_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_reg[i] <= rem_next[i];
            quo_reg[i] <= quo_next[i];
        end
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done    = busy_reg && (step_reg == 5'(SUM_W - 1));
    assign q_red   = quo_next[0][7:0];
    assign q_green = quo_next[1][7:0];
    assign q_blue  = quo_next[2][7:0];

endmodule

// File: rtl/core/box_blur_edge_normalized_top.sv
// per item: a pixel or drain item with no result due passes S_MUL and S_CMP only; with a result
// it also takes the back steps (up to 7), one read per window pixel (window rows * window cols,
// up to a 15x15 window) through one line store read port, and the 16-step serial divider,
// and it waits in S_OUT while the previous result is not yet taken.
// input tready is low while an item is in work.
// reset: async active low; radius 1, width 1024, height 768, counters cleared, store kept
module box_blur_edge_normalized_top
    import bbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_red, in_green, in_blue
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_red, out_green, out_blue, out_col, out_row, pad
    output logic        m_axis_tlast    // frame_last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_BACK  = 4'd3;
    localparam logic [3:0] S_START = 4'd4;
    localparam logic [3:0] S_READ  = 4'd5;
    localparam logic [3:0] S_FLUSH = 4'd6;
    localparam logic [3:0] S_DLOAD = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W+1)'(STORE_DEPTH);

    logic [3:0]        state_reg;
    logic [2:0]        radius_reg;
    logic [WCFG_W-1:0] width_reg;
    logic [HCFG_W-1:0] height_reg;
    logic [COL_W-1:0]  in_col_reg;
    logic [HCFG_W-1:0] in_row_reg;
    logic [LIN_W-1:0]  in_lin_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic [LIN_W-1:0]  prod_reg;
    logic [2:0]        back_reg;
    logic [ADDR_W-1:0] win_base_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] line_addr_reg;
    logic [COL_W-1:0]  x_reg;
    logic [ROW_W-1:0]  y_reg;
    logic [COL_W-1:0]  x0_reg, x1_reg;
    logic [ROW_W-1:0]  y0_reg, y1_reg;
    logic              acc_en_reg;
    sums_t             sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PIX_W-1:0]  rdata_reg;
    logic [PIX_W-1:0]  line_store [STORE_DEPTH];

    logic              m_valid_reg;
    logic [7:0]        o_red_reg, o_green_reg, o_blue_reg;
    logic [COL_W-1:0]  o_col_reg;
    logic [ROW_W-1:0]  o_row_reg;
    logic              o_last_reg;

    // effective register values
    logic [2:0]        r_eff;
    logic [WCFG_W-1:0] w_eff;
    logic [HCFG_W-1:0] h_eff;
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;
    logic [COL_W:0]    ox_r;
    logic [ROW_W:0]    oy_r;
    logic [COL_W-1:0]  nx;
    logic [ROW_W-1:0]  ny;
    logic [COL_W-1:0]  x0;
    logic [ROW_W-1:0]  y0;
    logic              frame_last;

    assign r_eff = (radius_reg == 3'd0) ? 3'd1 : radius_reg;
    assign w_eff = (width_reg == '0) ? WCFG_W'(1) :
                   (width_reg > WCFG_W'(MAX_WIDTH)) ? WCFG_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? HCFG_W'(1) :
                   (height_reg > HCFG_W'(MAX_HEIGHT)) ? HCFG_W'(MAX_HEIGHT) : height_reg;
    assign w_m1  = COL_W'(w_eff - WCFG_W'(1));
    assign h_m1  = ROW_W'(h_eff - HCFG_W'(1));
    assign ox_r  = {1'b0, out_col_reg} + (COL_W+1)'(r_eff);
    assign oy_r  = {1'b0, out_row_reg} + (ROW_W+1)'(r_eff);
    assign nx    = (ox_r > {1'b0, w_m1}) ? w_m1 : ox_r[COL_W-1:0];
    assign ny    = (oy_r > {1'b0, h_m1}) ? h_m1 : oy_r[ROW_W-1:0];
    assign x0    = (out_col_reg > COL_W'(r_eff)) ? out_col_reg - COL_W'(r_eff) : '0;
    assign y0    = (out_row_reg > ROW_W'(r_eff)) ? out_row_reg - ROW_W'(r_eff) : '0;
    assign frame_last = (out_col_reg == w_m1) && (out_row_reg == h_m1);

    logic in_acc, do_write, out_acc, out_load;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign do_write = in_acc && (s_axis_tuser == OP_PIXEL) && (in_row_reg < h_eff);
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_axis_tready);

    // address helpers, wrapped modulo the store depth
    logic [ADDR_W:0] wr_inc, rd_inc, line_inc, back_sub, start_sum, base_inc;
    assign wr_inc   = {1'b0, wr_addr_reg} + (ADDR_W+1)'(1);
    assign rd_inc   = {1'b0, rd_addr_reg} + (ADDR_W+1)'(1);
    assign line_inc = {1'b0, line_addr_reg} + (ADDR_W+1)'(w_eff);
    assign base_inc = {1'b0, row_base_reg} + (ADDR_W+1)'(w_eff);
    assign back_sub = ({1'b0, win_base_reg} >= (ADDR_W+1)'(w_eff)) ?
                      {1'b0, win_base_reg} - (ADDR_W+1)'(w_eff) :
                      {1'b0, win_base_reg} + DEPTH_X - (ADDR_W+1)'(w_eff);
    assign start_sum = {1'b0, win_base_reg} + (ADDR_W+1)'(x0_reg);

    logic [COL_W:0] in_col_inc;
    logic [COL_W:0] out_col_inc;
    assign in_col_inc  = {1'b0, in_col_reg} + (COL_W+1)'(1);
    assign out_col_inc = {1'b0, out_col_reg} + (COL_W+1)'(1);

    // window size from the clipped bounds
    logic [3:0] win_rows, win_cols;
    assign win_rows = 4'(y1_reg - y0_reg) + 4'd1;
    assign win_cols = 4'(x1_reg - x0_reg) + 4'd1;

    // divider
    logic div_done;
    logic [7:0] q_red, q_green, q_blue;
    bbe_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == S_DLOAD),
        .sums    (sum_reg),
        .divisor (cnt_reg),
        .done    (div_done),
        .q_red   (q_red),
        .q_green (q_green),
        .q_blue  (q_blue)
    );

    // line store
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            line_store[wr_addr_reg] <= s_axis_tdata;
        end
        if (state_reg == S_READ)
        begin
            rdata_reg <= line_store[rd_addr_reg];
        end
    end

    // sequencer and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            radius_reg   <= 3'd1;
            width_reg    <= WCFG_W'(1024);
            height_reg   <= HCFG_W'(768);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_lin_reg   <= '0;
            wr_addr_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            row_base_reg <= '0;
            acc_en_reg   <= 1'b0;
        end
        else
        begin
            acc_en_reg <= (state_reg == S_READ);
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_RADIUS: radius_reg <= cfg_data[2:0];
                    REG_WIDTH:  width_reg  <= cfg_data[WCFG_W-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[HCFG_W-1:0];
                    default:    ;
                endcase
                if (cfg_addr == REG_RADIUS || cfg_addr == REG_WIDTH ||
                    cfg_addr == REG_HEIGHT)
                begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_lin_reg   <= '0;
                    wr_addr_reg  <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    row_base_reg <= '0;
                end
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (in_acc)
                        begin
                            state_reg <= S_MUL;
                        end
                        if (do_write)
                        begin
                            in_lin_reg  <= in_lin_reg + LIN_W'(1);
                            wr_addr_reg <= (wr_inc == DEPTH_X) ? '0 : wr_inc[ADDR_W-1:0];
                            if (in_col_inc >= (COL_W+1)'(w_eff))
                            begin
                                in_col_reg <= '0;
                                in_row_reg <= in_row_reg + HCFG_W'(1);
                            end
                            else
                            begin
                                in_col_reg <= in_col_inc[COL_W-1:0];
                            end
                        end
                    end
                    S_MUL:
                    begin
                        state_reg <= S_CMP;
                    end
                    S_CMP:
                    begin
                        if (in_lin_reg > prod_reg + LIN_W'(nx))
                        begin
                            state_reg <= S_BACK;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_BACK:
                    begin
                        if (back_reg == 3'd0)
                        begin
                            state_reg <= S_START;
                        end
                    end
                    S_START:
                    begin
                        state_reg <= S_READ;
                    end
                    S_READ:
                    begin
                        if (x_reg == x1_reg && y_reg == y1_reg)
                        begin
                            state_reg <= S_FLUSH;
                        end
                    end
                    S_FLUSH:
                    begin
                        state_reg <= S_DLOAD;
                    end
                    S_DLOAD:
                    begin
                        state_reg <= S_DIV;
                    end
                    S_DIV:
                    begin
                        if (div_done)
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    S_OUT:
                    begin
                        if (out_load)
                        begin
                            state_reg <= S_IDLE;
                            if (frame_last)
                            begin
                                in_col_reg   <= '0;
                                in_row_reg   <= '0;
                                in_lin_reg   <= '0;
                                wr_addr_reg  <= '0;
                                out_col_reg  <= '0;
                                out_row_reg  <= '0;
                                row_base_reg <= '0;
                            end
                            else if (out_col_inc >= (COL_W+1)'(w_eff))
                            begin
                                out_col_reg  <= '0;
                                out_row_reg  <= out_row_reg + ROW_W'(1);
                                row_base_reg <= (base_inc >= DEPTH_X) ?
                                                ADDR_W'(base_inc - DEPTH_X) :
                                                base_inc[ADDR_W-1:0];
                            end
                            else
                            begin
                                out_col_reg <= out_col_inc[COL_W-1:0];
                            end
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // window datapath
    always_ff @(posedge clk)
    begin
        if (acc_en_reg)
        begin
            sum_reg.red   <= sum_reg.red   + SUM_W'(rdata_reg[7:0]);
            sum_reg.green <= sum_reg.green + SUM_W'(rdata_reg[15:8]);
            sum_reg.blue  <= sum_reg.blue  + SUM_W'(rdata_reg[23:16]);
        end
        case (state_reg)
            S_MUL:
            begin
                prod_reg <= LIN_W'(ny) * LIN_W'(w_eff);
                x0_reg   <= x0;
                x1_reg   <= nx;
                y0_reg   <= y0;
                y1_reg   <= ny;
                back_reg <= 3'(out_row_reg - y0);
                win_base_reg <= row_base_reg;
            end
            S_BACK:
            begin
                if (back_reg != 3'd0)
                begin
                    win_base_reg <= back_sub[ADDR_W-1:0];
                    back_reg     <= back_reg - 3'd1;
                end
            end
            S_START:
            begin
                rd_addr_reg   <= (start_sum >= DEPTH_X) ? ADDR_W'(start_sum - DEPTH_X) :
                                 start_sum[ADDR_W-1:0];
                line_addr_reg <= (start_sum >= DEPTH_X) ? ADDR_W'(start_sum - DEPTH_X) :
                                 start_sum[ADDR_W-1:0];
                x_reg   <= x0_reg;
                y_reg   <= y0_reg;
                sum_reg <= '0;
            end
            S_READ:
            begin
                if (x_reg == x1_reg)
                begin
                    x_reg <= x0_reg;
                    y_reg <= y_reg + ROW_W'(1);
                    rd_addr_reg   <= (line_inc >= DEPTH_X) ? ADDR_W'(line_inc - DEPTH_X) :
                                     line_inc[ADDR_W-1:0];
                    line_addr_reg <= (line_inc >= DEPTH_X) ? ADDR_W'(line_inc - DEPTH_X) :
                                     line_inc[ADDR_W-1:0];
                end
                else
                begin
                    x_reg       <= x_reg + COL_W'(1);
                    rd_addr_reg <= (rd_inc == DEPTH_X) ? '0 : rd_inc[ADDR_W-1:0];
                end
            end
            S_FLUSH:
            begin
                cnt_reg <= CNT_W'(win_rows) * CNT_W'(win_cols);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_acc)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV && div_done)
        begin
            o_red_reg   <= q_red;
            o_green_reg <= q_green;
            o_blue_reg  <= q_blue;
        end
        if (out_load)
        begin
            o_col_reg  <= out_col_reg;
            o_row_reg  <= out_row_reg;
            o_last_reg <= frame_last;
        end
    end

    logic [7:0] hold_red, hold_green, hold_blue;
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            hold_red   <= o_red_reg;
            hold_green <= o_green_reg;
            hold_blue  <= o_blue_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, o_row_reg, o_col_reg, hold_blue, hold_green, hold_red};
    assign m_axis_tlast  = o_last_reg;

    // checks
    a_wr_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_addr_reg < ADDR_W'(STORE_DEPTH))
        else $error("write address beyond line store");

    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_base_reg < ADDR_W'(STORE_DEPTH))
        else $error("row base beyond line store");

    a_read_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (x_reg <= x1_reg && y_reg <= y1_reg))
        else $error("window scan out of bounds");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_axis_tready))
        else $error("result overwritten before taken");

endmodule
